// File: rtl/core/json_string_unescape_defines.svh
// Assertion macros shared by the JSON string unescaper RTL.
// Expects i_clk and an active-low synchronous i_rst_n in the including module.
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define JSU_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/jsu_pkg.sv
// Shared types, codes and helper functions for the JSON string unescaper.
// No dependencies; used by jsu_decode, jsu_result_fifo and the top level.
package jsu_pkg;

    localparam int MAX_BURST  = 4;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    localparam logic [11:0] MAX_LEN_RESET = 12'd4090;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [3:0] ERR_NO_QUOTE    = 4'd0;
    localparam logic [3:0] ERR_TOO_LONG    = 4'd1;
    localparam logic [3:0] ERR_END_ESC     = 4'd2;
    localparam logic [3:0] ERR_SHORT_U     = 4'd3;
    localparam logic [3:0] ERR_BAD_HEX     = 4'd4;
    localparam logic [3:0] ERR_NO_SECOND   = 4'd5;
    localparam logic [3:0] ERR_BAD_HEX_LOW = 4'd6;
    localparam logic [3:0] ERR_NOT_LOW     = 4'd7;
    localparam logic [3:0] ERR_LONE_LOW    = 4'd8;
    localparam logic [3:0] ERR_UNTERM      = 4'd9;

    // source characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_SBS,
        PH_SU,
        PH_HEX2
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [3:0]  error_code;
        logic [11:0] string_length;
        logic        last;
    } t_result;

    // results caused by one accepted source byte, lowest index first
    typedef struct packed {
        logic [2:0]                count;
        t_result [MAX_BURST-1:0]   res;
    } t_burst;

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/jsu_decode.sv
// Decoder state machine and UTF-8 encoder: one source byte per transaction in,
// one burst of up to four results out. Depends on jsu_pkg and the defines header.
`include "json_string_unescape_defines.svh"

module jsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_at_end,
    input  logic             i_cfg_wr_en,
    input  logic [11:0]      i_cfg_wr_data,
    output jsu_pkg::t_burst  o_burst
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_hex_acc, n_hex_acc;
    logic [1:0]  r_digit_cnt, n_digit_cnt;
    logic [9:0]  r_hi_bits, n_hi_bits;
    logic [11:0] r_count, n_count;
    logic [11:0] r_max, n_max;

    // datapath
    logic [4:0]       hex;
    logic [15:0]      acc_shift;
    logic             last_digit;
    logic             is_high;
    logic             is_low;
    logic [20:0]      cp;
    logic [2:0]       utf_len;
    logic [3:0][7:0]  utf_b;
    logic             fits;

    // events for the current byte
    logic        e_err;
    logic [3:0]  e_code;
    logic        e_done;
    logic        e_byte;
    logic [7:0]  e_byte_val;
    logic        e_cp;

    always_comb begin
        hex        = jsu_pkg::hex_digit(i_byte);
        acc_shift  = {r_hex_acc[11:0], hex[3:0]};
        last_digit = (r_digit_cnt == 2'd3);
        is_high    = (acc_shift[15:10] == 6'b110110);
        is_low     = (acc_shift[15:10] == 6'b110111);
        if (r_phase == jsu_pkg::PH_HEX2) begin
            cp = 21'h10000 + {1'b0, r_hi_bits, acc_shift[9:0]};
        end else begin
            cp = {5'd0, acc_shift};
        end
    end

    always_comb begin
        utf_b = '0;
        if (cp < 21'h80) begin
            utf_len  = 3'd1;
            utf_b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            utf_len  = 3'd2;
            utf_b[0] = 8'hC0 | {3'b0, cp[10:6]};
            utf_b[1] = 8'h80 | {2'b0, cp[5:0]};
        end else if (cp < 21'h10000) begin
            utf_len  = 3'd3;
            utf_b[0] = 8'hE0 | {4'b0, cp[15:12]};
            utf_b[1] = 8'h80 | {2'b0, cp[11:6]};
            utf_b[2] = 8'h80 | {2'b0, cp[5:0]};
        end else begin
            utf_len  = 3'd4;
            utf_b[0] = 8'hF0 | {5'b0, cp[20:18]};
            utf_b[1] = 8'h80 | {2'b0, cp[17:12]};
            utf_b[2] = 8'h80 | {2'b0, cp[11:6]};
            utf_b[3] = 8'h80 | {2'b0, cp[5:0]};
        end
        fits = ({1'b0, r_count} + {10'b0, utf_len}) <= {1'b0, r_max};
    end

    // classify the byte against the current phase
    always_comb begin
        e_err      = 1'b0;
        e_code     = jsu_pkg::ERR_NO_QUOTE;
        e_done     = 1'b0;
        e_byte     = 1'b0;
        e_byte_val = i_byte;
        e_cp       = 1'b0;
        unique case (r_phase) inside
            jsu_pkg::PH_BODY: begin
                if (i_at_end) begin
                    e_err  = 1'b1;
                    e_code = jsu_pkg::ERR_UNTERM;
                end else if (i_byte == jsu_pkg::CH_QUOTE) begin
                    e_done = 1'b1;
                end else if (r_count >= r_max) begin
                    e_err  = 1'b1;
                    e_code = jsu_pkg::ERR_TOO_LONG;
                end else if (i_byte != jsu_pkg::CH_BSLASH) begin
                    e_byte = 1'b1;
                end
            end
            jsu_pkg::PH_ESC: begin
                if (i_at_end) begin
                    e_err  = 1'b1;
                    e_code = jsu_pkg::ERR_END_ESC;
                end else if (i_byte != jsu_pkg::CH_U) begin
                    e_byte     = 1'b1;
                    e_byte_val = jsu_pkg::esc_map(i_byte);
                end
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                if (i_at_end) begin
                    e_err  = 1'b1;
                    e_code = (r_phase == jsu_pkg::PH_HEX2) ? jsu_pkg::ERR_NO_SECOND
                                                           : jsu_pkg::ERR_SHORT_U;
                end else if (!hex[4]) begin
                    e_err  = 1'b1;
                    e_code = (r_phase == jsu_pkg::PH_HEX2) ? jsu_pkg::ERR_BAD_HEX_LOW
                                                           : jsu_pkg::ERR_BAD_HEX;
                end else if (last_digit) begin
                    if (r_phase == jsu_pkg::PH_HEX1 && is_low) begin
                        e_err  = 1'b1;
                        e_code = jsu_pkg::ERR_LONE_LOW;
                    end else if (r_phase == jsu_pkg::PH_HEX2 && !is_low) begin
                        e_err  = 1'b1;
                        e_code = jsu_pkg::ERR_NOT_LOW;
                    end else if (r_phase == jsu_pkg::PH_HEX2 || !is_high) begin
                        if (fits) begin
                            e_cp = 1'b1;
                        end else begin
                            e_err  = 1'b1;
                            e_code = jsu_pkg::ERR_TOO_LONG;
                        end
                    end
                end
            end
            jsu_pkg::PH_SBS: begin
                if (i_at_end || i_byte != jsu_pkg::CH_BSLASH) begin
                    e_err  = 1'b1;
                    e_code = jsu_pkg::ERR_NO_SECOND;
                end
            end
            jsu_pkg::PH_SU: begin
                if (i_at_end || i_byte != jsu_pkg::CH_U) begin
                    e_err  = 1'b1;
                    e_code = jsu_pkg::ERR_NO_SECOND;
                end
            end
            default: begin
                // waiting for the opening quote
                if (i_at_end || i_byte != jsu_pkg::CH_QUOTE) begin
                    e_err = 1'b1;
                end
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_hex_acc   = r_hex_acc;
        n_digit_cnt = r_digit_cnt;
        n_hi_bits   = r_hi_bits;
        n_count     = r_count;
        n_max       = i_cfg_wr_en ? i_cfg_wr_data : r_max;
        if (i_accept) begin
            if (e_err || e_done) begin
                n_phase     = jsu_pkg::PH_WAIT;
                n_hex_acc   = '0;
                n_digit_cnt = '0;
                n_hi_bits   = '0;
                n_count     = '0;
            end else begin
                unique case (r_phase) inside
                    jsu_pkg::PH_BODY: begin
                        if (e_byte) begin
                            n_count = r_count + 12'd1;
                        end else begin
                            n_phase = jsu_pkg::PH_ESC;
                        end
                    end
                    jsu_pkg::PH_ESC: begin
                        if (e_byte) begin
                            n_phase = jsu_pkg::PH_BODY;
                            n_count = r_count + 12'd1;
                        end else begin
                            n_phase     = jsu_pkg::PH_HEX1;
                            n_hex_acc   = '0;
                            n_digit_cnt = '0;
                        end
                    end
                    jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                        if (e_cp) begin
                            n_phase     = jsu_pkg::PH_BODY;
                            n_count     = r_count + {9'b0, utf_len};
                            n_hex_acc   = '0;
                            n_digit_cnt = '0;
                        end else if (!last_digit) begin
                            n_hex_acc   = acc_shift;
                            n_digit_cnt = r_digit_cnt + 2'd1;
                        end else begin
                            // high surrogate: hold its payload for the pair
                            n_phase     = jsu_pkg::PH_SBS;
                            n_hi_bits   = acc_shift[9:0];
                            n_hex_acc   = '0;
                            n_digit_cnt = '0;
                        end
                    end
                    jsu_pkg::PH_SBS: begin
                        n_phase = jsu_pkg::PH_SU;
                    end
                    jsu_pkg::PH_SU: begin
                        n_phase     = jsu_pkg::PH_HEX2;
                        n_hex_acc   = '0;
                        n_digit_cnt = '0;
                    end
                    default: begin
                        n_phase = jsu_pkg::PH_BODY;
                    end
                endcase
            end
        end
    end

    // result burst
    always_comb begin
        logic [2:0] last_idx;
        last_idx = utf_len - 3'd1;
        o_burst  = '0;
        if (i_accept) begin
            if (e_err) begin
                o_burst.count             = 3'd1;
                o_burst.res[0].kind       = jsu_pkg::KIND_ERR;
                o_burst.res[0].error_code = e_code;
                o_burst.res[0].last       = 1'b1;
            end else if (e_done) begin
                o_burst.count                = 3'd1;
                o_burst.res[0].kind          = jsu_pkg::KIND_DONE;
                o_burst.res[0].string_length = r_count;
                o_burst.res[0].last          = 1'b1;
            end else if (e_byte) begin
                o_burst.count           = 3'd1;
                o_burst.res[0].kind     = jsu_pkg::KIND_BYTE;
                o_burst.res[0].out_byte = e_byte_val;
                o_burst.res[0].last     = 1'b1;
            end else if (e_cp) begin
                o_burst.count = utf_len;
                for (int i = 0; i < jsu_pkg::MAX_BURST; i++) begin
                    o_burst.res[i].kind     = jsu_pkg::KIND_BYTE;
                    o_burst.res[i].out_byte = utf_b[i];
                    o_burst.res[i].last     = (last_idx[1:0] == 2'(i));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= jsu_pkg::PH_WAIT;
            r_hex_acc   <= '0;
            r_digit_cnt <= '0;
            r_hi_bits   <= '0;
            r_count     <= '0;
            r_max       <= jsu_pkg::MAX_LEN_RESET;
        end else begin
            r_phase     <= n_phase;
            r_hex_acc   <= n_hex_acc;
            r_digit_cnt <= n_digit_cnt;
            r_hi_bits   <= n_hi_bits;
            r_count     <= n_count;
            r_max       <= n_max;
        end
    end

    `JSU_ASSERT_NEXT(a_err_goes_idle, i_accept && e_err, r_phase == jsu_pkg::PH_WAIT && r_count == 12'd0, "error did not return decoder to idle")
    `JSU_ASSERT_NEXT(a_quote_opens, i_accept && r_phase == jsu_pkg::PH_WAIT && !e_err, r_phase == jsu_pkg::PH_BODY && r_count == 12'd0, "opening quote did not start a string")
    `JSU_ASSERT(a_hex_only_in_hex, r_digit_cnt == 2'd0 || r_phase == jsu_pkg::PH_HEX1 || r_phase == jsu_pkg::PH_HEX2, "digit count left over outside hex phase")

endmodule

// File: rtl/core/jsu_result_fifo.sv
// Result queue: takes a burst of up to four results per cycle, drains one per
// transaction on the output stream. Depends on jsu_pkg and the defines header.
`include "json_string_unescape_defines.svh"

module jsu_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jsu_pkg::t_burst  i_burst,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output jsu_pkg::t_result o_result
);

    jsu_pkg::t_result [jsu_pkg::FIFO_DEPTH-1:0] r_mem;
    logic [jsu_pkg::FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [jsu_pkg::FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [jsu_pkg::FIFO_AW:0]   r_count, n_count;

    logic [jsu_pkg::FIFO_DEPTH-1:0]              w_we;
    jsu_pkg::t_result [jsu_pkg::FIFO_DEPTH-1:0]  w_data;
    logic                                        pop;

    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    // room for a full burst
    assign o_space  = (r_count <= (jsu_pkg::FIFO_AW + 1)'(jsu_pkg::FIFO_DEPTH - jsu_pkg::MAX_BURST));
    assign pop      = o_valid && i_ready;

    always_comb begin
        logic [jsu_pkg::FIFO_AW-1:0] off;
        for (int j = 0; j < jsu_pkg::FIFO_DEPTH; j++) begin
            off       = jsu_pkg::FIFO_AW'(j) - r_wr_ptr;
            w_we[j]   = ({1'b0, off} < {1'b0, i_burst.count});
            w_data[j] = i_burst.res[off[1:0]];
        end
        n_wr_ptr = r_wr_ptr + i_burst.count;
        n_rd_ptr = r_rd_ptr + jsu_pkg::FIFO_AW'(pop);
        n_count  = r_count + {1'b0, i_burst.count} - (jsu_pkg::FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < jsu_pkg::FIFO_DEPTH; j++) begin
            if (w_we[j]) begin
                r_mem[j] <= w_data[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `JSU_ASSERT(a_no_overflow, i_burst.count == 3'd0 || o_space, "burst written without room")
    `JSU_ASSERT_NEXT(a_drain_empty, pop && r_count == 4'd1 && i_burst.count == 3'd0, !o_valid, "queue not empty after last result drained")

endmodule

// File: rtl/core/json_string_unescape.sv
// JSON string unescaper, top level.
// Input stream: one source byte per transaction, s_axis_tdata = byte_value,
//   s_axis_tuser = at_end (source exhausted, data ignored). Start at the
//   opening quote; a quote, a backslash escape or a \uXXXX escape (pairs
//   included) are decoded, every other byte passes through.
// Output stream: one result per transaction. m_axis_tuser = kind (decoded
//   byte, string complete, error); m_axis_tdata carries out_byte, error_code
//   and string_length; m_axis_tlast marks the final result of one input byte.
// Configuration: i_cfg_wr_en writes max_length; the user must do so only while the block is idle;
//   the block does not enforce this. Results are registered into the result queue and offered in order.
// Throughput: one source byte per cycle while each byte gives at most one
//   result and m_axis_tready is high; a \u escape that becomes up to four UTF-8
//   bytes drains one per cycle while m_axis_tready is high, from an eight-entry
//   result queue, and input is held whenever the queue has less room than four results.
// Reset: synchronous, active low; the decoder waits for an opening quote,
//   max_length returns to 4090 and the queue empties.
// Stall: with m_axis_tready low, results stay queued and input stops once
//   the queue cannot take another full burst.
module json_string_unescape (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic [0:0]  s_axis_tuser,   // [0] at_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [11:8] error_code, [23:12] string_length
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [11:0] i_cfg_wr_data
);

    jsu_pkg::t_burst  burst;
    jsu_pkg::t_result result;
    logic             space;
    logic             accept;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    jsu_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_byte        (s_axis_tdata),
        .i_at_end      (s_axis_tuser[0]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_burst       (burst)
    );

    jsu_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_burst  (burst),
        .o_space  (space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {result.string_length, result.error_code, result.out_byte};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

endmodule

// File: bench/testbench.sv
// Self-checking bench for json_string_unescape: a directed table of source bytes,
// then random JSON string tokens over several max_length settings and idle patterns.
// Depends only on jsu_pkg and the json_string_unescape RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // far above the slowest run: ~250 source bytes, four results each, heavy stalls
    localparam int CYCLE_LIMIT = 200_000;
    localparam int PHASE_ITEMS = 20;

    typedef struct packed {
        logic [7:0]  data;
        logic        at_end;
        logic        pinned;     // typed-in result replaces the predicted one
        logic [1:0]  pin_kind;
        logic [3:0]  pin_code;
        logic [11:0] pin_len;
    } t_src_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [0:0]  s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_wr_en = 1'b0;
    logic [11:0] i_cfg_wr_data = 12'd0;

    json_string_unescape uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // decoder state of the predictor
    logic [11:0]     max_len     = jsu_pkg::MAX_LEN_RESET;
    jsu_pkg::t_phase dec_phase   = jsu_pkg::PH_WAIT;
    logic [15:0]     hex_acc     = 16'd0;
    logic [1:0]      hex_digits  = 2'd0;
    logic [9:0]      hi_bits     = 10'd0;
    logic [11:0]     decoded_len = 12'd0;

    jsu_pkg::t_result step_results[$];
    jsu_pkg::t_result unescaped_q[$];
    t_src_item        json_src_q[$];
    t_src_item        cur_item = '0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int queued_items   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    logic [7:0] simple_escapes [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                                       "/", "n", "r", "t", "b", "f"};

    t_src_item directed_rows [28] = '{
        '{"x",                1'b0, 1'b1, jsu_pkg::KIND_ERR,  jsu_pkg::ERR_NO_QUOTE, 12'd0},
        '{8'hFF,              1'b1, 1'b1, jsu_pkg::KIND_ERR,  jsu_pkg::ERR_NO_QUOTE, 12'd0},
        '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{8'h00,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{8'hFF,              1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"n",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        // code point zero
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{jsu_pkg::CH_U,      1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"0",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"0",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"0",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"0",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        // surrogate pair for U+1F600, four UTF-8 bytes
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{jsu_pkg::CH_U,      1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"D",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"8",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"3",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"d",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{jsu_pkg::CH_U,      1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"D",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"E",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"0",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{"0",                1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{jsu_pkg::CH_QUOTE,  1'b0, 1'b1, jsu_pkg::KIND_DONE, 4'd0, 12'd8},
        '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0},
        '{8'h00,              1'b1, 1'b1, jsu_pkg::KIND_ERR,  jsu_pkg::ERR_UNTERM, 12'd0}
    };

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] escaped_char(input logic [7:0] c);
        case (c)
            "n":     return 8'h0A;
            "r":     return 8'h0D;
            "t":     return 8'h09;
            "b":     return 8'h08;
            "f":     return 8'h0C;
            default: return c;
        endcase
    endfunction

    // ---------------- predictor ----------------

    task automatic push_result(input logic [1:0] kind, input logic [7:0] b,
                               input logic [3:0] code, input logic [11:0] len);
        jsu_pkg::t_result r;
        r.kind          = kind;
        r.out_byte      = b;
        r.error_code    = code;
        r.string_length = len;
        r.last          = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic go_idle();
        dec_phase   = jsu_pkg::PH_WAIT;
        hex_acc     = 16'd0;
        hex_digits  = 2'd0;
        hi_bits     = 10'd0;
        decoded_len = 12'd0;
    endtask

    task automatic fail_string(input logic [3:0] code);
        push_result(jsu_pkg::KIND_ERR, 8'd0, code, 12'd0);
        go_idle();
    endtask

    task automatic emit_decoded(input logic [7:0] b);
        push_result(jsu_pkg::KIND_BYTE, b, 4'd0, 12'd0);
        decoded_len = decoded_len + 12'd1;
    endtask

    task automatic emit_codepoint(input logic [20:0] cp);
        logic [7:0] seq [4];
        int n;
        int i;
        if (cp < 21'h80) begin
            n = 1;
            seq[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            n = 2;
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            n = 3;
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
        end else begin
            n = 4;
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
        end
        // the whole sequence must fit, or nothing of it goes out
        if (int'(decoded_len) + n > int'(max_len)) begin
            fail_string(jsu_pkg::ERR_TOO_LONG);
        end else begin
            for (i = 0; i < n; i++) push_result(jsu_pkg::KIND_BYTE, seq[i], 4'd0, 12'd0);
            decoded_len = decoded_len + 12'(n);
            dec_phase   = jsu_pkg::PH_BODY;
            hex_acc     = 16'd0;
            hex_digits  = 2'd0;
        end
    endtask

    task automatic unescape_step(input logic [7:0] b, input logic src_end);
        int d;
        step_results.delete();
        case (dec_phase)
            jsu_pkg::PH_BODY: begin
                if (src_end) begin
                    fail_string(jsu_pkg::ERR_UNTERM);
                end else if (b == jsu_pkg::CH_QUOTE) begin
                    push_result(jsu_pkg::KIND_DONE, 8'd0, 4'd0, decoded_len);
                    go_idle();
                end else if (decoded_len >= max_len) begin
                    fail_string(jsu_pkg::ERR_TOO_LONG);
                end else if (b == jsu_pkg::CH_BSLASH) begin
                    dec_phase = jsu_pkg::PH_ESC;
                end else begin
                    emit_decoded(b);
                end
            end
            jsu_pkg::PH_ESC: begin
                if (src_end) begin
                    fail_string(jsu_pkg::ERR_END_ESC);
                end else if (b == jsu_pkg::CH_U) begin
                    dec_phase  = jsu_pkg::PH_HEX1;
                    hex_acc    = 16'd0;
                    hex_digits = 2'd0;
                end else begin
                    dec_phase = jsu_pkg::PH_BODY;
                    emit_decoded(escaped_char(b));
                end
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                d = hex_nibble(b);
                if (src_end) begin
                    fail_string(dec_phase == jsu_pkg::PH_HEX1 ? jsu_pkg::ERR_SHORT_U
                                                              : jsu_pkg::ERR_NO_SECOND);
                end else if (d < 0) begin
                    fail_string(dec_phase == jsu_pkg::PH_HEX1 ? jsu_pkg::ERR_BAD_HEX
                                                              : jsu_pkg::ERR_BAD_HEX_LOW);
                end else begin
                    hex_acc = {hex_acc[11:0], 4'(d)};
                    if (hex_digits < 2'd3) begin
                        hex_digits++;
                    end else begin
                        hex_digits = 2'd0;
                        if (dec_phase == jsu_pkg::PH_HEX1) begin
                            if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                                hi_bits   = hex_acc[9:0];
                                hex_acc   = 16'd0;
                                dec_phase = jsu_pkg::PH_SBS;
                            end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                                fail_string(jsu_pkg::ERR_LONE_LOW);
                            end else begin
                                emit_codepoint({5'd0, hex_acc});
                            end
                        end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                            fail_string(jsu_pkg::ERR_NOT_LOW);
                        end else begin
                            emit_codepoint(21'h10000 + {hi_bits, 10'd0} + hex_acc[9:0]);
                        end
                    end
                end
            end
            jsu_pkg::PH_SBS: begin
                if (src_end || b != jsu_pkg::CH_BSLASH) fail_string(jsu_pkg::ERR_NO_SECOND);
                else dec_phase = jsu_pkg::PH_SU;
            end
            jsu_pkg::PH_SU: begin
                if (src_end || b != jsu_pkg::CH_U) begin
                    fail_string(jsu_pkg::ERR_NO_SECOND);
                end else begin
                    dec_phase  = jsu_pkg::PH_HEX2;
                    hex_acc    = 16'd0;
                    hex_digits = 2'd0;
                end
            end
            default: begin
                if (src_end || b != jsu_pkg::CH_QUOTE) begin
                    fail_string(jsu_pkg::ERR_NO_QUOTE);
                end else begin
                    go_idle();
                    dec_phase = jsu_pkg::PH_BODY;
                end
            end
        endcase
    endtask

    // ---------------- source side ----------------

    always @(posedge i_clk) begin : drive_source
        t_src_item nxt;
        int        i;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                unescape_step(s_axis_tdata, s_axis_tuser[0]);
                if (cur_item.pinned) begin
                    step_results.delete();
                    push_result(cur_item.pin_kind, 8'd0, cur_item.pin_code, cur_item.pin_len);
                end
                if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
                for (i = 0; i < step_results.size(); i++) unescaped_q.push_back(step_results[i]);
            end
            // hold an offered transaction until it is taken
            if (!s_axis_tvalid || s_axis_tready) begin
                if (json_src_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    nxt = json_src_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tuser  <= nxt.at_end;
                    cur_item      <= nxt;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result side ----------------

    always @(posedge i_clk) begin : check_results
        jsu_pkg::t_result got;
        jsu_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind          = m_axis_tuser;
            got.out_byte      = m_axis_tdata[7:0];
            got.error_code    = m_axis_tdata[11:8];
            got.string_length = m_axis_tdata[23:12];
            got.last          = m_axis_tlast;
            if (unescaped_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result kind %0d byte %h err %0d len %0d",
                              got.kind, got.out_byte, got.error_code, got.string_length));
            end else begin
                want = unescaped_q.pop_front();
                if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                    got.error_code !== want.error_code ||
                    got.string_length !== want.string_length || got.last !== want.last) begin
                    flag_mismatch($sformatf(
                        "kind %0d/%0d byte %h/%h err %0d/%0d len %0d/%0d last %0d/%0d (got/want)",
                        got.kind, want.kind, got.out_byte, want.out_byte,
                        got.error_code, want.error_code, got.string_length,
                        want.string_length, got.last, want.last));
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ---------------- stimulus ----------------

    task automatic push_src(input logic [7:0] b, input logic src_end);
        t_src_item it;
        it = '{b, src_end, 1'b0, jsu_pkg::KIND_BYTE, 4'd0, 12'd0};
        json_src_q.push_back(it);
        queued_items++;
    endtask

    // backslash, u, then the leading ndig hex digits of v in random case
    task automatic push_u_escape(input logic [15:0] v, input int ndig);
        logic [3:0] nib;
        int i;
        push_src(jsu_pkg::CH_BSLASH, 1'b0);
        push_src(jsu_pkg::CH_U, 1'b0);
        for (i = 0; i < ndig; i++) begin
            nib = v[15 - 4 * i -: 4];
            if (nib < 4'd10) push_src("0" + 8'(nib), 1'b0);
            else push_src(($urandom_range(0, 1) ? "a" : "A") + 8'(nib) - 8'd10, 1'b0);
        end
    endtask

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do c = 8'($urandom); while (hex_nibble(c) >= 0);
        return c;
    endfunction

    function automatic logic [15:0] high_surrogate();
        return 16'hD800 | 16'($urandom_range(0, 1023));
    endfunction

    task automatic build_string();
        int          n_elem;
        int          j;
        int          pick;
        int          k;
        logic [15:0] cp;
        logic [7:0]  b;
        // stray byte outside any string
        if ($urandom_range(0, 7) == 0) begin
            b = 8'($urandom);
            push_src(b, (b == jsu_pkg::CH_QUOTE) ? 1'b1 : 1'($urandom_range(0, 1)));
        end
        push_src(jsu_pkg::CH_QUOTE, 1'b0);
        n_elem = $urandom_range(0, 10);
        for (j = 0; j < n_elem; j++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                do b = 8'($urandom); while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
                push_src(b, 1'b0);
            end else if (pick < 6) begin
                push_src(jsu_pkg::CH_BSLASH, 1'b0);
                k = $urandom_range(0, 9);
                if (k < 8) b = simple_escapes[k];
                else do b = 8'($urandom); while (b == jsu_pkg::CH_U);
                push_src(b, 1'b0);
            end else if (pick < 8) begin
                case ($urandom_range(0, 2))
                    0:       cp = 16'($urandom_range(0, 16'h7F));
                    1:       cp = 16'($urandom_range(16'h80, 16'h7FF));
                    default: cp = 16'($urandom_range(16'h800, 16'hFFFF));
                endcase
                if (cp >= 16'hD800 && cp <= 16'hDFFF) cp ^= 16'h8000;
                push_u_escape(cp, 4);
            end else begin
                push_u_escape(high_surrogate(), 4);
                push_u_escape(16'hDC00 | 16'($urandom_range(0, 1023)), 4);
            end
        end
        if ($urandom_range(0, 4) != 0) begin
            push_src(jsu_pkg::CH_QUOTE, 1'b0);
        end else begin
            // broken token: stop at the fault, the block goes back to waiting
            k = $urandom_range(0, 3);
            case ($urandom_range(0, 7))
                0: push_src(8'($urandom), 1'b1);
                1: begin
                    push_src(jsu_pkg::CH_BSLASH, 1'b0);
                    push_src(8'($urandom), 1'b1);
                end
                2: begin
                    push_u_escape(16'($urandom), k);
                    push_src(8'($urandom), 1'b1);
                end
                3: begin
                    push_u_escape(16'($urandom), k);
                    push_src(non_hex_char(), 1'b0);
                end
                4: begin
                    push_u_escape(high_surrogate(), 4);
                    case ($urandom_range(0, 4))
                        0: push_src(8'($urandom), 1'b1);
                        1: begin
                            do b = 8'($urandom); while (b == jsu_pkg::CH_BSLASH);
                            push_src(b, 1'b0);
                        end
                        2: begin
                            push_src(jsu_pkg::CH_BSLASH, 1'b0);
                            push_src(8'($urandom), 1'b1);
                        end
                        3: begin
                            push_src(jsu_pkg::CH_BSLASH, 1'b0);
                            do b = 8'($urandom); while (b == jsu_pkg::CH_U);
                            push_src(b, 1'b0);
                        end
                        default: begin
                            push_u_escape(16'($urandom), k);
                            push_src(8'($urandom), 1'b1);
                        end
                    endcase
                end
                5: begin
                    push_u_escape(high_surrogate(), 4);
                    push_u_escape(16'($urandom), k);
                    push_src(non_hex_char(), 1'b0);
                end
                6: begin
                    push_u_escape(high_surrogate(), 4);
                    cp = 16'($urandom);
                    if (cp >= 16'hDC00 && cp <= 16'hDFFF) cp ^= 16'h4000;
                    push_u_escape(cp, 4);
                end
                default: push_u_escape(16'hDC00 | 16'($urandom_range(0, 1023)), 4);
            endcase
        end
    endtask

    // settle at the falling edge so pending handshakes are visible
    task automatic wait_drained();
        while (json_src_q.size() != 0 || s_axis_tvalid || unescaped_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_max_length(input logic [11:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        max_len = v;
    endtask

    task automatic run_phase(input logic [11:0] limit, input int src_pct, input int sink_pct);
        set_max_length(limit);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        queued_items   = 0;
        while (queued_items < PHASE_ITEMS) build_string();
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) json_src_q.push_back(directed_rows[i]);
        wait_drained();

        run_phase(12'd4095, 0, 0);
        run_phase(12'd1, 59, 0);
        run_phase(12'd6, 0, 59);
        run_phase(12'd20, 36, 36);
        run_phase(12'($urandom_range(2, 40)), 59, 0);
        run_phase(jsu_pkg::MAX_LEN_RESET, 0, 59);

        repeat (8) @(posedge i_clk);
        if (unescaped_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", unescaped_q.size()));
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
